// File: rtl/cfmp_pkg.sv
package cfmp_pkg;

    // Length limit of one expression and the width of the byte counter.
    localparam int MAX_EXPR_LEN = 255;
    localparam int CNT_W        = $clog2(MAX_EXPR_LEN + 1);

    // Mask widths of the five fields.
    localparam int MINUTE_W  = 60;
    localparam int HOUR_W    = 24;
    localparam int DAY_W     = 31;
    localparam int MONTH_W   = 12;
    localparam int WEEKDAY_W = 7;

    // Result packing on the output stream.
    localparam int RESULT_W   = MINUTE_W + HOUR_W + DAY_W + MONTH_W + WEEKDAY_W + 1;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Field numbers; FLD_DONE means all five fields are complete.
    localparam logic [2:0] FLD_MINUTE  = 3'd0;
    localparam logic [2:0] FLD_HOUR    = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_MONTH   = 3'd3;
    localparam logic [2:0] FLD_WEEKDAY = 3'd4;
    localparam logic [2:0] FLD_DONE    = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] NUM_SAT      = 8'd255;
    localparam logic [7:0] WEEKDAY_ALT  = 8'd7;

    // Parser phase within a field.
    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_START      = 8'b0000_0010,
        PH_LO         = 8'b0000_0100,
        PH_HI_FIRST   = 8'b0000_1000,
        PH_HI         = 8'b0001_0000,
        PH_STEP_FIRST = 8'b0010_0000,
        PH_STEP       = 8'b0100_0000,
        PH_TAIL       = 8'b1000_0000
    } phase_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic [2:0] field_number;
        phase_t     phase;
        logic [7:0] number_acc;
        logic [7:0] range_low;
        logic [7:0] range_high;
        logic [7:0] step_size;
        logic       star_seen;
        logic       single_digit;
        logic       error_seen;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        field_number: FLD_MINUTE,
        phase:        PH_IDLE,
        number_acc:   8'd0,
        range_low:    8'd0,
        range_high:   8'd0,
        step_size:    8'd1,
        star_seen:    1'b0,
        single_digit: 1'b0,
        error_seen:   1'b0
    };

    // Request to the fill unit: set bits low, low+step, ... up to high.
    typedef struct packed {
        logic       valid;
        logic [2:0] field;
        logic [5:0] low;
        logic [5:0] high;
        logic [7:0] step;
    } fill_req_t;

    function automatic logic [5:0] field_min(input logic [2:0] f);
        logic [5:0] v;
        case (f)
            FLD_DAY:   v = 6'd1;
            FLD_MONTH: v = 6'd1;
            default:   v = 6'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] field_max(input logic [2:0] f);
        logic [5:0] v;
        case (f)
            FLD_MINUTE: v = 6'd59;
            FLD_HOUR:   v = 6'd23;
            FLD_DAY:    v = 6'd31;
            FLD_MONTH:  v = 6'd12;
            default:    v = 6'd6;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/cfmp_decode.sv
module cfmp_decode
    import cfmp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   char_code,
    input  logic         end_only,
    output parse_state_t nxt,
    output fill_req_t    req
);

    typedef struct packed {
        parse_state_t st;
        fill_req_t    req;
        logic         ok;
    } step_res_t;

    // Bound value, with a lone weekday 7 read as Sunday.
    function automatic logic [7:0] bound_value(input parse_state_t s);
        logic [7:0] v;
        if (s.field_number == FLD_WEEKDAY && s.single_digit && s.number_acc == WEEKDAY_ALT)
            v = 8'd0;
        else
            v = s.number_acc;
        return v;
    endfunction

    // Check the element against the field range and hand it to the fill unit.
    function automatic step_res_t close_element(input parse_state_t s);
        step_res_t  r;
        logic [5:0] fmin;
        logic [5:0] fmax;
        r.st  = s;
        r.req = '0;
        r.ok  = !s.error_seen;
        fmin  = field_min(s.field_number);
        fmax  = field_max(s.field_number);
        if (s.field_number <= FLD_WEEKDAY)
        begin
            if (s.range_low < {2'b00, fmin} || s.range_high > {2'b00, fmax} ||
                s.range_low > s.range_high || s.step_size == 8'd0)
            begin
                r.st.error_seen = 1'b1;
                r.ok            = 1'b0;
            end
            else
            begin
                r.req.valid       = 1'b1;
                r.req.field       = s.field_number;
                r.req.low         = s.range_low[5:0];
                r.req.high        = s.range_high[5:0];
                r.req.step        = s.step_size;
                r.st.star_seen    = 1'b0;
                r.st.step_size    = 8'd1;
                r.st.number_acc   = 8'd0;
                r.st.single_digit = 1'b0;
            end
        end
        return r;
    endfunction

    // Close whatever element the current phase holds open.
    function automatic step_res_t end_element(input parse_state_t s);
        step_res_t    r;
        parse_state_t t;
        t     = s;
        r.st  = s;
        r.req = '0;
        r.ok  = 1'b0;
        case (s.phase)
            PH_LO:
            begin
                t.range_low  = bound_value(s);
                t.range_high = bound_value(s);
                r = close_element(t);
            end
            PH_HI:
            begin
                if (!s.star_seen)
                    t.range_high = bound_value(s);
                r = close_element(t);
            end
            PH_STEP:
            begin
                t.step_size = s.number_acc;
                r = close_element(t);
            end
            PH_TAIL:
            begin
                r.ok = 1'b1;
            end
            default:
            begin
                r.st.error_seen = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Field separator or end of text: close the field and move to the next one.
    function automatic step_res_t end_field(input parse_state_t s);
        step_res_t r;
        r.st  = s;
        r.req = '0;
        r.ok  = 1'b1;
        if (s.phase != PH_IDLE && s.field_number < FLD_DONE)
        begin
            r = end_element(s);
            if (r.ok)
            begin
                r.st.field_number = s.field_number + 3'd1;
                r.st.phase        = PH_IDLE;
            end
        end
        return r;
    endfunction

    // Accumulate one decimal digit, saturating at the top of the byte.
    function automatic parse_state_t take_digit(input parse_state_t s, input logic [3:0] d,
                                                input phase_t next_phase);
        parse_state_t t;
        logic         fresh;
        logic [11:0]  v;
        t     = s;
        fresh = (s.phase == PH_START || s.phase == PH_IDLE ||
                 s.phase == PH_HI_FIRST || s.phase == PH_STEP_FIRST);
        v     = ({4'b0000, s.number_acc} << 3) + ({4'b0000, s.number_acc} << 1) +
                {8'b0000_0000, d};
        if (fresh)
        begin
            t.number_acc   = {4'b0000, d};
            t.single_digit = 1'b1;
        end
        else
        begin
            t.number_acc   = (v > {4'b0000, NUM_SAT}) ? NUM_SAT : v[7:0];
            t.single_digit = 1'b0;
        end
        t.phase = next_phase;
        return t;
    endfunction

    // One character of the expression.
    function automatic step_res_t take_char(input parse_state_t s, input logic [7:0] c);
        step_res_t  r;
        logic       digit;
        logic       ows;
        logic       tail;
        logic [5:0] fmin;
        logic [5:0] fmax;
        r.st  = s;
        r.req = '0;
        r.ok  = 1'b1;
        tail  = 1'b0;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        ows   = (c >= CH_LF && c <= CH_CR);
        fmin  = field_min(s.field_number);
        fmax  = field_max(s.field_number);
        if (c == CH_SPACE || c == CH_TAB)
        begin
            r = end_field(s);
        end
        else if (s.field_number <= FLD_WEEKDAY)
        begin
            case (s.phase)
                PH_IDLE, PH_START:
                begin
                    if (digit)
                        r.st = take_digit(s, c[3:0], PH_LO);
                    else if (c == CH_STAR)
                    begin
                        r.st.star_seen  = 1'b1;
                        r.st.range_low  = {2'b00, fmin};
                        r.st.range_high = {2'b00, fmax};
                        r.st.phase      = PH_HI;
                    end
                    else if (ows)
                        r.st.phase = PH_START;
                    else
                        r.st.error_seen = 1'b1;
                end
                PH_LO:
                begin
                    if (digit)
                        r.st = take_digit(s, c[3:0], PH_LO);
                    else if (c == CH_DASH)
                    begin
                        r.st.range_low = bound_value(s);
                        r.st.phase     = PH_HI_FIRST;
                    end
                    else if (c == CH_SLASH)
                    begin
                        r.st.range_low  = bound_value(s);
                        r.st.range_high = {2'b00, fmax};
                        r.st.phase      = PH_STEP_FIRST;
                    end
                    else
                        tail = 1'b1;
                end
                PH_HI_FIRST:
                begin
                    if (digit)
                        r.st = take_digit(s, c[3:0], PH_HI);
                    else
                        r.st.error_seen = 1'b1;
                end
                PH_STEP_FIRST:
                begin
                    if (digit)
                        r.st = take_digit(s, c[3:0], PH_STEP);
                    else
                        r.st.error_seen = 1'b1;
                end
                PH_HI:
                begin
                    if (digit && !s.star_seen)
                        r.st = take_digit(s, c[3:0], PH_HI);
                    else if (c == CH_SLASH)
                    begin
                        if (!s.star_seen)
                            r.st.range_high = bound_value(s);
                        r.st.phase = PH_STEP_FIRST;
                    end
                    else if (digit)
                        r.st.error_seen = 1'b1;
                    else
                        tail = 1'b1;
                end
                PH_STEP:
                begin
                    if (digit)
                        r.st = take_digit(s, c[3:0], PH_STEP);
                    else
                        tail = 1'b1;
                end
                default:
                begin
                    tail = 1'b1;
                end
            endcase

            // After a complete element only a comma or other whitespace may follow.
            if (tail)
            begin
                if (c == CH_COMMA)
                begin
                    r = end_element(s);
                    if (r.ok)
                        r.st.phase = PH_START;
                end
                else if (ows)
                begin
                    r = end_element(s);
                    if (r.ok)
                        r.st.phase = PH_TAIL;
                end
                else
                    r.st.error_seen = 1'b1;
            end
        end
        return r;
    endfunction

    step_res_t res;

    // Either a character step or a bare field close at the end of the text.
    always_comb
    begin
        if (end_only)
            res = end_field(cur);
        else
            res = take_char(cur, char_code);
        nxt = res.st;
        req = res.req;
    end

endmodule

// File: rtl/cfmp_fill.sv
module cfmp_fill
    import cfmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fill_req_t            req,
    input  logic                 clear,
    output logic                 busy,
    output logic [MINUTE_W-1:0]  minute_bits,
    output logic [HOUR_W-1:0]    hour_bits,
    output logic [DAY_W-1:0]     day_bits,
    output logic [MONTH_W-1:0]   month_bits,
    output logic [WEEKDAY_W-1:0] weekday_bits
);

    logic                 busy_reg;
    logic [2:0]           field_reg;
    logic [5:0]           idx_reg;
    logic [5:0]           high_reg;
    logic [7:0]           step_reg;
    logic [MINUTE_W-1:0]  minute_reg;
    logic [HOUR_W-1:0]    hour_reg;
    logic [DAY_W-1:0]     day_reg;
    logic [MONTH_W-1:0]   month_reg;
    logic [WEEKDAY_W-1:0] weekday_reg;

    logic [5:0]           bit_pos;
    logic [MINUTE_W-1:0]  bit_sel;
    logic [8:0]           idx_sum;
    logic                 last_step;

    // One adder and one compare, reused for every bit of a range.
    assign bit_pos   = idx_reg - field_min(field_reg);
    assign bit_sel   = {{(MINUTE_W-1){1'b0}}, 1'b1} << bit_pos;
    assign idx_sum   = {3'b000, idx_reg} + {1'b0, step_reg};
    assign last_step = idx_sum > {3'b000, high_reg};

    // Walk the range one set bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            field_reg   <= FLD_MINUTE;
            idx_reg     <= 6'd0;
            high_reg    <= 6'd0;
            step_reg    <= 8'd1;
            minute_reg  <= '0;
            hour_reg    <= '0;
            day_reg     <= '0;
            month_reg   <= '0;
            weekday_reg <= '0;
        end
        else if (clear)
        begin
            busy_reg    <= 1'b0;
            minute_reg  <= '0;
            hour_reg    <= '0;
            day_reg     <= '0;
            month_reg   <= '0;
            weekday_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            field_reg <= req.field;
            idx_reg   <= req.low;
            high_reg  <= req.high;
            step_reg  <= req.step;
        end
        else if (busy_reg)
        begin
            case (field_reg)
                FLD_MINUTE:  minute_reg  <= minute_reg | bit_sel;
                FLD_HOUR:    hour_reg    <= hour_reg | bit_sel[HOUR_W-1:0];
                FLD_DAY:     day_reg     <= day_reg | bit_sel[DAY_W-1:0];
                FLD_MONTH:   month_reg   <= month_reg | bit_sel[MONTH_W-1:0];
                default:     weekday_reg <= weekday_reg | bit_sel[WEEKDAY_W-1:0];
            endcase
            idx_reg  <= idx_sum[5:0];
            busy_reg <= !last_step;
        end
    end

    assign busy         = busy_reg;
    assign minute_bits  = minute_reg;
    assign hour_bits    = hour_reg;
    assign day_bits     = day_reg;
    assign month_bits   = month_reg;
    assign weekday_bits = weekday_reg;

endmodule

// File: rtl/cron_field_mask_parser.sv
// Each byte passes through a request step (SQ_IDLE) and a decode step (SQ_CHAR); a byte that
// closes an element adds a bit fill (SQ_FILL) that sets the element's bits one at a time.
// The last byte adds a field close, a possible bit fill and a step that loads the result.
// The bit fill uses a single adder; one byte is in work at a time.
// Reset (asynchronous, active low) clears the parser, the masks and the output valid flag.
module cron_field_mask_parser
    import cfmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // char_code[7:0]
    input  logic                  s_tlast,   // last_char
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // minute_mask[59:0], hour_mask[83:60], day_mask[114:84], month_mask[126:115],
    // weekday_mask[133:127], parse_ok[134], zero pad[135]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [4:0] {
        SQ_IDLE = 5'b00001,
        SQ_CHAR = 5'b00010,
        SQ_FILL = 5'b00100,
        SQ_END  = 5'b01000,
        SQ_OUT  = 5'b10000
    } seq_t;

    seq_t                  state_reg, state_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  end_pass_reg, end_pass_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    parse_state_t          parse_reg, parse_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    parse_state_t          dec_state;
    fill_req_t             dec_req;
    logic                  dec_end;
    logic                  fill_start;
    logic                  fill_clear;
    logic                  fill_busy;
    logic                  parse_ok;
    logic [MINUTE_W-1:0]   minute_bits;
    logic [HOUR_W-1:0]     hour_bits;
    logic [DAY_W-1:0]      day_bits;
    logic [MONTH_W-1:0]    month_bits;
    logic [WEEKDAY_W-1:0]  weekday_bits;

    // A NUL byte and the end of text both only close the open field.
    assign dec_end = (state_reg == SQ_END) || (char_reg == CH_NUL);

    cfmp_decode u_decode
    (
        .cur       (parse_reg),
        .char_code (char_reg),
        .end_only  (dec_end),
        .nxt       (dec_state),
        .req       (dec_req)
    );

    cfmp_fill u_fill
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (fill_start),
        .req          (dec_req),
        .clear        (fill_clear),
        .busy         (fill_busy),
        .minute_bits  (minute_bits),
        .hour_bits    (hour_bits),
        .day_bits     (day_bits),
        .month_bits   (month_bits),
        .weekday_bits (weekday_bits)
    );

    assign parse_ok = !parse_reg.error_seen && parse_reg.field_number == FLD_DONE;

    // Sequencer: take a byte, decode it, fill bits, close and deliver on the last byte.
    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        end_pass_next  = end_pass_reg;
        count_next     = count_reg;
        parse_next     = parse_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        fill_start     = 1'b0;
        fill_clear     = 1'b0;
        case (state_reg)
            SQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    char_next  = s_tdata;
                    last_next  = s_tlast;
                    state_next = SQ_CHAR;
                end
            end
            SQ_CHAR:
            begin
                end_pass_next = 1'b0;
                if (count_reg < CNT_W'(MAX_EXPR_LEN))
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (!parse_reg.error_seen)
                    begin
                        parse_next = dec_state;
                        fill_start = dec_req.valid;
                        if (char_reg == CH_NUL)
                            count_next = CNT_W'(MAX_EXPR_LEN);
                    end
                end
                if (fill_start)
                    state_next = SQ_FILL;
                else if (last_reg)
                    state_next = SQ_END;
                else
                    state_next = SQ_IDLE;
            end
            SQ_FILL:
            begin
                if (!fill_busy)
                begin
                    if (end_pass_reg)
                        state_next = SQ_OUT;
                    else if (last_reg)
                        state_next = SQ_END;
                    else
                        state_next = SQ_IDLE;
                end
            end
            SQ_END:
            begin
                end_pass_next = 1'b1;
                if (!parse_reg.error_seen)
                begin
                    parse_next = dec_state;
                    fill_start = dec_req.valid;
                end
                state_next = fill_start ? SQ_FILL : SQ_OUT;
            end
            SQ_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, parse_ok,
                                      parse_ok ? weekday_bits : {WEEKDAY_W{1'b0}},
                                      parse_ok ? month_bits : {MONTH_W{1'b0}},
                                      parse_ok ? day_bits : {DAY_W{1'b0}},
                                      parse_ok ? hour_bits : {HOUR_W{1'b0}},
                                      parse_ok ? minute_bits : {MINUTE_W{1'b0}}};
                    parse_next     = PARSE_RESET;
                    count_next     = '0;
                    fill_clear     = 1'b1;
                    state_next     = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Control and parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            end_pass_reg  <= 1'b0;
            count_reg     <= '0;
            parse_reg     <= PARSE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_pass_reg  <= end_pass_next;
            count_reg     <= count_next;
            parse_reg     <= parse_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload and result data.
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == SQ_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
